[src/lts_pkg.sv]
package lts_pkg;

  localparam int MAX_WAYS  = 64;
  localparam int KEY_BITS  = 32;
  localparam int SRC_W     = $clog2(MAX_WAYS);
  localparam int KEY_W     = KEY_BITS;
  localparam int WAYS_W    = $clog2(MAX_WAYS) + 1;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 1'b1;

  localparam logic [WAYS_W-1:0] ACTIVE_WAYS_RST = WAYS_W'(MAX_WAYS);

  // request types
  localparam logic REQ_CLEAR  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic [SRC_W-1:0] winner_source;
    logic [KEY_W-1:0] winner_key;
    logic             winner_valid;
    logic             all_sources_done;
  } result_t;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CLEAR = 7'b0000100,
    S_NODE  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_WREAD = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

[src/lts_if.sv]
interface lts_req_if import lts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [SRC_W-1:0] source_index;
  logic [KEY_W-1:0] new_key;
  logic             source_done;

  modport source (output valid, req_type, source_index, new_key, source_done, input ready);
  modport sink   (input valid, req_type, source_index, new_key, source_done, output ready);
endinterface

interface lts_rsp_if import lts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] winner_source;
  logic [KEY_W-1:0] winner_key;
  logic             winner_valid;
  logic             all_sources_done;

  modport source (output valid, winner_source, winner_key, winner_valid, all_sources_done,
                  input ready);
  modport sink   (input valid, winner_source, winner_key, winner_valid, all_sources_done,
                  output ready);
endinterface

interface lts_cfg_if import lts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WAYS_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/lts_ram.sv]
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lts_match.sv]
module lts_match #(
  parameter int KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] held_key,
  input  logic                held_done,
  input  logic [KEY_BITS-1:0] climb_key,
  input  logic                climb_done,
  input  logic                descending,
  output logic                stored_wins
);

  logic better;

  // strict compare, so equal keys leave the climbing source in front
  assign better = descending ? (held_key > climb_key) : (held_key < climb_key);

  // a done source loses to one that is not done; if both are done, the climbing source wins
  assign stored_wins = !held_done && (climb_done || better);

endmodule

[src/loser_tree_merge_selector_core.sv]
// Loser tree for a k-way merge. Each source has a head key and a done flag in a
// leaf memory, and each inner node of the tree keeps the source that lost the
// match played there, in a node memory. A clear item empties every inner node
// and the winner; an update item stores the source's key and flag and replays
// the path from its leaf toward the root, one level at a time: the node
// memory read returns the stored loser, then the leaf memory read returns that
// loser's key for the match. The climb passes up to log2 of active_ways levels
// (rounded up) and ends early at an empty node; a single-source update finishes
// straight from the idle state, an out-of-range source returns the stored
// winner or no winner if there is none, and a clear makes a pass over the node
// memory. After reset a pass over every address initializes both memories
// before the first item is accepted. One item is worked at a time; a finished
// result waits in an output register while the next item is taken in.
module loser_tree_merge_selector_core import lts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lts_req_if.sink       req,
  lts_rsp_if.source     rsp,
  lts_cfg_if.sink       cfg
);

  localparam int IW     = $clog2(MAX_WAYS);
  localparam int NW     = IW + 1;
  localparam int NODE_W = IW + 1;
  localparam int LEAF_W = KEY_BITS + 1;

  localparam logic [NODE_W-1:0] NODE_EMPTY = {1'b1, {IW{1'b0}}};

  state_t               state;
  logic [WAYS_W-1:0]    active_ways;
  logic                 descending;
  logic [NW-1:0]        sweep_cnt;
  logic [IW-1:0]        parent;
  logic [IW-1:0]        climb_src;
  logic [KEY_BITS-1:0]  climb_key;
  logic                 climb_done;
  logic [IW-1:0]        held_src;
  logic [NODE_W-1:0]    winner_reg;
  result_t              res;
  result_t              rsp_res;
  logic                 rsp_valid;
  logic                 rsp_load;

  logic [NW-1:0]        n;
  logic [NW-1:0]        leaf_pos;
  logic [IW-1:0]        parent0;
  logic [IW-1:0]        np;
  logic                 in_range;
  logic                 single;
  logic                 sweep_last;

  logic                 leaf_we, leaf_re;
  logic [IW-1:0]        leaf_waddr, leaf_raddr;
  logic [LEAF_W-1:0]    leaf_wdata, leaf_rdata;
  logic                 node_we, node_re;
  logic [IW-1:0]        node_waddr, node_raddr;
  logic [NODE_W-1:0]    node_wdata, node_rdata;

  logic                 stored_wins;
  logic [IW-1:0]        nxt_src;
  logic [KEY_BITS-1:0]  nxt_key;
  logic                 nxt_done;

  lts_ram #(.WIDTH(LEAF_W), .DEPTH(MAX_WAYS)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  lts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_WAYS)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  lts_match #(.KEY_BITS(KEY_BITS)) u_match (
    .held_key    (leaf_rdata[KEY_BITS-1:0]),
    .held_done   (leaf_rdata[KEY_BITS]),
    .climb_key   (climb_key),
    .climb_done  (climb_done),
    .descending  (descending),
    .stored_wins (stored_wins)
  );

  // ways in use, clamped to 1..MAX_WAYS
  always_comb begin
    if (active_ways == '0) begin
      n = NW'(1);
    end else if (32'(active_ways) > 32'(MAX_WAYS)) begin
      n = NW'(MAX_WAYS);
    end else begin
      n = NW'(active_ways);
    end
  end

  assign leaf_pos   = n + NW'(req.source_index);
  assign parent0    = leaf_pos[NW-1:1];
  assign np         = IW'(parent >> 1);
  assign in_range   = 32'(req.source_index) < 32'(n);
  assign single     = (n == NW'(1));
  assign sweep_last = (sweep_cnt == NW'(MAX_WAYS - 1));
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp.ready);

  assign nxt_src  = stored_wins ? held_src : climb_src;
  assign nxt_key  = stored_wins ? leaf_rdata[KEY_BITS-1:0] : climb_key;
  assign nxt_done = stored_wins ? leaf_rdata[KEY_BITS] : climb_done;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid            = rsp_valid;
  assign rsp.winner_source    = rsp_res.winner_source;
  assign rsp.winner_key       = rsp_res.winner_key;
  assign rsp.winner_valid     = rsp_res.winner_valid;
  assign rsp.all_sources_done = rsp_res.all_sources_done;

  // memory port control
  always_comb begin
    leaf_we    = 1'b0;
    leaf_waddr = sweep_cnt[IW-1:0];
    leaf_wdata = '0;
    leaf_re    = 1'b0;
    leaf_raddr = node_rdata[IW-1:0];
    node_we    = 1'b0;
    node_waddr = sweep_cnt[IW-1:0];
    node_wdata = NODE_EMPTY;
    node_re    = 1'b0;
    node_raddr = parent0;
    unique case (state)
      S_INIT: begin
        leaf_we = 1'b1;
        node_we = 1'b1;
      end
      S_CLEAR: begin
        node_we = 1'b1;
      end
      S_IDLE: begin
        if (req.valid && req.req_type == REQ_UPDATE) begin
          if (in_range) begin
            leaf_we    = 1'b1;
            leaf_waddr = IW'(req.source_index);
            leaf_wdata = {req.source_done, KEY_BITS'(req.new_key)};
            node_re    = !single;
          end else if (!winner_reg[IW]) begin
            leaf_re    = 1'b1;
            leaf_raddr = winner_reg[IW-1:0];
          end
        end
      end
      S_NODE: begin
        if (node_rdata[IW]) begin
          // empty node takes the climbing source and ends the climb
          node_we    = 1'b1;
          node_waddr = parent;
          node_wdata = {1'b0, climb_src};
        end else begin
          leaf_re    = 1'b1;
          node_re    = (np != '0);
          node_raddr = np;
        end
      end
      S_CMP: begin
        if (stored_wins) begin
          node_we    = 1'b1;
          node_waddr = parent;
          node_wdata = {1'b0, climb_src};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_cnt   <= '0;
      winner_reg  <= NODE_EMPTY;
      active_ways <= ACTIVE_WAYS_RST;
      descending  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_ACTIVE_WAYS: active_ways <= cfg.data;
          CFG_DESCENDING:  descending  <= cfg.data[0];
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          if (sweep_last) begin
            sweep_cnt <= '0;
            state     <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + NW'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            if (req.req_type == REQ_CLEAR) begin
              winner_reg <= NODE_EMPTY;
              state      <= S_CLEAR;
            end else if (!in_range) begin
              if (winner_reg[IW]) begin
                res   <= '0;
                state <= S_DONE;
              end else begin
                state <= S_WREAD;
              end
            end else if (single) begin
              winner_reg           <= '0;
              res.winner_source    <= '0;
              res.winner_key       <= KEY_W'(KEY_BITS'(req.new_key));
              res.winner_valid     <= 1'b1;
              res.all_sources_done <= req.source_done;
              state                <= S_DONE;
            end else begin
              climb_src  <= IW'(req.source_index);
              climb_key  <= KEY_BITS'(req.new_key);
              climb_done <= req.source_done;
              parent     <= parent0;
              state      <= S_NODE;
            end
          end
        end
        S_CLEAR: begin
          if (sweep_last) begin
            sweep_cnt <= '0;
            res       <= '0;
            state     <= S_DONE;
          end else begin
            sweep_cnt <= sweep_cnt + NW'(1);
          end
        end
        S_NODE: begin
          held_src <= node_rdata[IW-1:0];
          if (node_rdata[IW]) begin
            res   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          climb_src  <= nxt_src;
          climb_key  <= nxt_key;
          climb_done <= nxt_done;
          parent     <= np;
          if (np == '0) begin
            // climb passed the root
            winner_reg           <= {1'b0, nxt_src};
            res.winner_source    <= SRC_W'(nxt_src);
            res.winner_key       <= KEY_W'(nxt_key);
            res.winner_valid     <= 1'b1;
            res.all_sources_done <= nxt_done;
            state                <= S_DONE;
          end else begin
            state <= S_NODE;
          end
        end
        S_WREAD: begin
          res.winner_source    <= SRC_W'(winner_reg[IW-1:0]);
          res.winner_key       <= KEY_W'(leaf_rdata[KEY_BITS-1:0]);
          res.winner_valid     <= 1'b1;
          res.all_sources_done <= leaf_rdata[KEY_BITS];
          state                <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_res <= res;
            state   <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  a_no_winner_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.winner_valid) |->
      (rsp.winner_source == '0 && rsp.winner_key == '0 && !rsp.all_sources_done))
    else $error("no-winner item carries nonzero fields");

  a_empty_only_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (node_we && state != S_INIT && state != S_CLEAR) |-> !node_wdata[IW])
    else $error("replay wrote an empty marker into a node");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

  a_cmp_after_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(state == S_NODE && !node_rdata[IW]))
    else $error("match played without a filled node read");

endmodule
